// File: rtl/visit_event_detector_unit_defines.svh
// Assertion macros shared by the visit event detector RTL.
// Included by the top level, which checks its own logic; the bodies vanish under SYNTHESIS.
`ifndef VISIT_EVENT_DETECTOR_UNIT_DEFINES_SVH
`define VISIT_EVENT_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VEDU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VEDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VEDU_ASSERT_IMPL(lbl, ante, cons, msg)
`define VEDU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/vedu_pkg.sv
// Package for the visit event detector: widths, register indexes, reset values
// and the item, result and configuration structs. No dependencies.
`default_nettype none

package vedu_pkg;

    localparam int TIME_W     = 32;
    localparam int WEIGHT_W   = 19;
    localparam int LEVEL_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VISIT_THRESHOLD     = 3'd0,
        REG_MOTION_WINDOW_MS    = 3'd1,
        REG_IDLE_TIMEOUT_MS     = 3'd2,
        REG_SMALL_MIN_DELTA     = 3'd3,
        REG_SMALL_EVAL_DELAY_MS = 3'd4,
        REG_SMALL_COOLDOWN_MS   = 3'd5
    } reg_index_t;

    localparam logic [LEVEL_W-1:0] RST_VISIT_THRESHOLD     = 18'd50;
    localparam logic [TIME_W-1:0]  RST_MOTION_WINDOW_MS    = 32'd2000;
    localparam logic [TIME_W-1:0]  RST_IDLE_TIMEOUT_MS     = 32'd5000;
    localparam logic [LEVEL_W-1:0] RST_SMALL_MIN_DELTA     = 18'd20;
    localparam logic [TIME_W-1:0]  RST_SMALL_EVAL_DELAY_MS = 32'd1000;
    localparam logic [TIME_W-1:0]  RST_SMALL_COOLDOWN_MS   = 32'd30000;

    typedef struct packed {
        logic [LEVEL_W-1:0] visit_threshold;
        logic [TIME_W-1:0]  motion_window_ms;
        logic [TIME_W-1:0]  idle_timeout_ms;
        logic [LEVEL_W-1:0] small_min_delta;
        logic [TIME_W-1:0]  small_eval_delay_ms;
        logic [TIME_W-1:0]  small_cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]          now_ms;
        logic                       motion_trigger;
        logic [TIME_W-1:0]          trigger_time;
        logic                       weight_valid;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       capture_accepted;
    } sample_t;

    typedef struct packed {
        logic                capture_request;
        logic [WEIGHT_W-1:0] capture_delta;
        logic                visit_started;
        logic [WEIGHT_W-1:0] start_rise;
        logic                visit_ended;
        logic [TIME_W-1:0]   visit_begin_time;
        logic [TIME_W-1:0]   visit_duration;
        logic [WEIGHT_W-1:0] visit_peak;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/vedu_ifs.sv
// Valid/ready channel interfaces for the visit event detector: scale samples in,
// detection results out. Depends on vedu_pkg for the field widths.
`default_nettype none

interface vedu_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [vedu_pkg::TIME_W-1:0]          now_ms;
    logic                                 motion_trigger;
    logic [vedu_pkg::TIME_W-1:0]          trigger_time;
    logic                                 weight_valid;
    logic signed [vedu_pkg::WEIGHT_W-1:0] weight;
    logic                                 capture_accepted;

    modport source (
        output valid, now_ms, motion_trigger, trigger_time, weight_valid, weight,
               capture_accepted,
        input  ready
    );
    modport sink (
        input  valid, now_ms, motion_trigger, trigger_time, weight_valid, weight,
               capture_accepted,
        output ready
    );
endinterface

interface vedu_event_if;
    logic                          valid;
    logic                          ready;
    logic                          capture_request;
    logic [vedu_pkg::WEIGHT_W-1:0] capture_delta;
    logic                          visit_started;
    logic [vedu_pkg::WEIGHT_W-1:0] start_rise;
    logic                          visit_ended;
    logic [vedu_pkg::TIME_W-1:0]   visit_begin_time;
    logic [vedu_pkg::TIME_W-1:0]   visit_duration;
    logic [vedu_pkg::WEIGHT_W-1:0] visit_peak;

    modport source (
        output valid, capture_request, capture_delta, visit_started, start_rise,
               visit_ended, visit_begin_time, visit_duration, visit_peak,
        input  ready
    );
    modport sink (
        input  valid, capture_request, capture_delta, visit_started, start_rise,
               visit_ended, visit_begin_time, visit_duration, visit_peak,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/vedu_cfg.sv
// Configuration register bank of the visit event detector.
// Depends on vedu_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module vedu_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [vedu_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [vedu_pkg::CFG_DATA_W-1:0]    wr_data,
    output vedu_pkg::cfg_t                     cfg
);
    import vedu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_VISIT_THRESHOLD:     cfg_next.visit_threshold     = wr_data[LEVEL_W-1:0];
                REG_MOTION_WINDOW_MS:    cfg_next.motion_window_ms    = wr_data[TIME_W-1:0];
                REG_IDLE_TIMEOUT_MS:     cfg_next.idle_timeout_ms     = wr_data[TIME_W-1:0];
                REG_SMALL_MIN_DELTA:     cfg_next.small_min_delta     = wr_data[LEVEL_W-1:0];
                REG_SMALL_EVAL_DELAY_MS: cfg_next.small_eval_delay_ms = wr_data[TIME_W-1:0];
                REG_SMALL_COOLDOWN_MS:   cfg_next.small_cooldown_ms   = wr_data[TIME_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.visit_threshold     <= RST_VISIT_THRESHOLD;
            cfg_reg.motion_window_ms    <= RST_MOTION_WINDOW_MS;
            cfg_reg.idle_timeout_ms     <= RST_IDLE_TIMEOUT_MS;
            cfg_reg.small_min_delta     <= RST_SMALL_MIN_DELTA;
            cfg_reg.small_eval_delay_ms <= RST_SMALL_EVAL_DELAY_MS;
            cfg_reg.small_cooldown_ms   <= RST_SMALL_COOLDOWN_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/vedu_core.sv
// Detection state and per-sample decision logic of the visit event detector.
// Depends on vedu_pkg for sample_t, result_t and cfg_t.
`default_nettype none

module vedu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  vedu_pkg::cfg_t      cfg,
    input  vedu_pkg::sample_t   smp,
    output vedu_pkg::result_t   res
);
    import vedu_pkg::*;

    logic                       cand_active_reg,   cand_active_next;
    logic [TIME_W-1:0]          cand_deadline_reg, cand_deadline_next;
    logic [TIME_W-1:0]          cand_start_reg,    cand_start_next;
    logic signed [WEIGHT_W-1:0] cand_base_reg,     cand_base_next;
    logic                       small_pending_reg, small_pending_next;
    logic signed [WEIGHT_W-1:0] small_base_reg,    small_base_next;
    logic [TIME_W-1:0]          small_due_reg,     small_due_next;
    logic [TIME_W-1:0]          last_capture_reg,  last_capture_next;
    logic                       in_visit_reg,      in_visit_next;
    logic signed [WEIGHT_W-1:0] visit_base_reg,    visit_base_next;
    logic [TIME_W-1:0]          visit_begin_reg,   visit_begin_next;
    logic [TIME_W-1:0]          last_busy_reg,     last_busy_next;
    logic signed [WEIGHT_W-1:0] peak_seen_reg,     peak_seen_next;

    // Differences of two 19-bit signed values need one extra bit.
    logic [WEIGHT_W:0]   small_diff;
    logic [WEIGHT_W-1:0] small_abs;
    logic [WEIGHT_W:0]   cand_diff;
    logic [WEIGHT_W:0]   visit_diff;
    logic [WEIGHT_W-1:0] visit_rise;
    logic [WEIGHT_W:0]   peak_diff;

    always_comb
    begin
        cand_active_next   = cand_active_reg;
        cand_deadline_next = cand_deadline_reg;
        cand_start_next    = cand_start_reg;
        cand_base_next     = cand_base_reg;
        small_pending_next = small_pending_reg;
        small_base_next    = small_base_reg;
        small_due_next     = small_due_reg;
        last_capture_next  = last_capture_reg;
        in_visit_next      = in_visit_reg;
        visit_base_next    = visit_base_reg;
        visit_begin_next   = visit_begin_reg;
        last_busy_next     = last_busy_reg;
        peak_seen_next     = peak_seen_reg;
        res                = '0;
        small_diff         = '0;
        small_abs          = '0;
        cand_diff          = '0;
        visit_diff         = '0;
        visit_rise         = '0;
        peak_diff          = '0;

        if (smp.motion_trigger)
        begin
            if (in_visit_reg)
            begin
                last_busy_next = smp.now_ms;
            end
            if (!smp.weight_valid)
            begin
                cand_active_next   = 1'b0;
                small_pending_next = 1'b0;
            end
            else
            begin
                cand_active_next   = 1'b1;
                cand_deadline_next = smp.trigger_time + cfg.motion_window_ms;
                cand_start_next    = smp.trigger_time;
                cand_base_next     = smp.weight;
                small_pending_next = 1'b1;
                small_base_next    = smp.weight;
                small_due_next     = smp.trigger_time + cfg.small_eval_delay_ms;
            end
        end

        if (!smp.weight_valid)
        begin
            small_pending_next = 1'b0;
        end
        else
        begin
            // Small-event check once its due time has come.
            if (small_pending_next && (smp.now_ms >= small_due_next))
            begin
                small_diff = {smp.weight[WEIGHT_W-1], smp.weight}
                           - {small_base_next[WEIGHT_W-1], small_base_next};
                small_abs  = small_diff[WEIGHT_W] ? WEIGHT_W'(-small_diff)
                                                  : small_diff[WEIGHT_W-1:0];
                small_pending_next = 1'b0;
                if ((small_abs >= {1'b0, cfg.small_min_delta})
                    && ((smp.now_ms - last_capture_reg) >= cfg.small_cooldown_ms))
                begin
                    res.capture_request = 1'b1;
                    res.capture_delta   = small_abs;
                    if (smp.capture_accepted)
                    begin
                        last_capture_next = smp.now_ms;
                    end
                end
            end

            // Candidate window: a large enough rise opens (or replaces) a visit.
            if (cand_active_next)
            begin
                cand_diff = {smp.weight[WEIGHT_W-1], smp.weight}
                          - {cand_base_next[WEIGHT_W-1], cand_base_next};
                if (smp.now_ms > cand_deadline_next)
                begin
                    cand_active_next = 1'b0;
                end
                else if (!cand_diff[WEIGHT_W]
                         && (cand_diff[WEIGHT_W-1:0] >= {1'b0, cfg.visit_threshold}))
                begin
                    in_visit_next     = 1'b1;
                    visit_base_next   = cand_base_next;
                    visit_begin_next  = cand_start_next;
                    last_busy_next    = smp.now_ms;
                    peak_seen_next    = smp.weight;
                    res.visit_started = 1'b1;
                    res.start_rise    = cand_diff[WEIGHT_W-1:0];
                    cand_active_next  = 1'b0;
                end
            end

            // Open visit: peak tracking, activity and idle timeout.
            if (in_visit_next)
            begin
                if ($signed(smp.weight) > $signed(peak_seen_next))
                begin
                    peak_seen_next = smp.weight;
                end
                visit_diff = {smp.weight[WEIGHT_W-1], smp.weight}
                           - {visit_base_next[WEIGHT_W-1], visit_base_next};
                visit_rise = visit_diff[WEIGHT_W] ? '0 : visit_diff[WEIGHT_W-1:0];
                if (visit_rise >= {1'b0, cfg.visit_threshold})
                begin
                    last_busy_next = smp.now_ms;
                end
                if ((smp.now_ms - last_busy_next) >= cfg.idle_timeout_ms)
                begin
                    peak_diff = {peak_seen_next[WEIGHT_W-1], peak_seen_next}
                              - {visit_base_next[WEIGHT_W-1], visit_base_next};
                    in_visit_next        = 1'b0;
                    res.visit_ended      = 1'b1;
                    res.visit_begin_time = visit_begin_next;
                    res.visit_duration   = smp.now_ms - visit_begin_next;
                    res.visit_peak       = peak_diff[WEIGHT_W] ? '0
                                                               : peak_diff[WEIGHT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_active_reg   <= 1'b0;
            cand_deadline_reg <= '0;
            cand_start_reg    <= '0;
            cand_base_reg     <= '0;
            small_pending_reg <= 1'b0;
            small_base_reg    <= '0;
            small_due_reg     <= '0;
            last_capture_reg  <= '0;
            in_visit_reg      <= 1'b0;
            visit_base_reg    <= '0;
            visit_begin_reg   <= '0;
            last_busy_reg     <= '0;
            peak_seen_reg     <= '0;
        end
        else if (go)
        begin
            cand_active_reg   <= cand_active_next;
            cand_deadline_reg <= cand_deadline_next;
            cand_start_reg    <= cand_start_next;
            cand_base_reg     <= cand_base_next;
            small_pending_reg <= small_pending_next;
            small_base_reg    <= small_base_next;
            small_due_reg     <= small_due_next;
            last_capture_reg  <= last_capture_next;
            in_visit_reg      <= in_visit_next;
            visit_base_reg    <= visit_base_next;
            visit_begin_reg   <= visit_begin_next;
            last_busy_reg     <= last_busy_next;
            peak_seen_reg     <= peak_seen_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/visit_event_detector_unit.sv
// Visit event detector top level: input register, decision core, result register.
// Depends on vedu_pkg, vedu_ifs, vedu_cfg, vedu_core and the assertion header.
//
// Usage:
// Scale samples arrive on the samples channel (valid/ready), one item per tick,
// and every accepted item yields exactly one result item on the events channel.
// A result carries the small-event capture request, the visit start flag with
// its rise, and the visit end flag with begin time, duration and peak.
// An item is held in an input register; the decision logic then writes the
// result register, which offers the result on the events channel. One item is
// accepted in every cycle while the events channel takes results.
// When the receiver stalls, the result stays in the result register and one
// further item may wait in the input register; ready drops only when both
// are full. After reset both registers are empty, all detection state is zero
// and the configuration registers hold their defaults. The user must write
// configuration through wr_en, wr_index and wr_data only while no items are
// in flight; the block does not enforce this.
`default_nettype none

`include "visit_event_detector_unit_defines.svh"

module visit_event_detector_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    vedu_sample_if.sink                     samples,
    vedu_event_if.source                    events,
    input  logic                            wr_en,
    input  logic [vedu_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [vedu_pkg::CFG_DATA_W-1:0] wr_data
);
    import vedu_pkg::*;

    cfg_t    cfg;
    sample_t s1_reg;
    sample_t s1_next;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    result_t core_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    take_in;

    vedu_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    vedu_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .cfg   (cfg),
        .smp   (s1_reg),
        .res   (core_res)
    );

    // The held item moves on whenever the result register is free or emptying.
    assign advance       = s1_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !s1_valid_reg || advance;
    assign take_in       = samples.valid && samples.ready;

    always_comb
    begin
        s1_next.now_ms           = samples.now_ms;
        s1_next.motion_trigger   = samples.motion_trigger;
        s1_next.trigger_time     = samples.trigger_time;
        s1_next.weight_valid     = samples.weight_valid;
        s1_next.weight           = samples.weight;
        s1_next.capture_accepted = samples.capture_accepted;
        s1_valid_next            = take_in || (s1_valid_reg && !advance);
        out_valid_next           = advance || (out_valid_reg && !events.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_reg <= s1_next;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign events.valid            = out_valid_reg;
    assign events.capture_request  = out_res_reg.capture_request;
    assign events.capture_delta    = out_res_reg.capture_delta;
    assign events.visit_started    = out_res_reg.visit_started;
    assign events.start_rise       = out_res_reg.start_rise;
    assign events.visit_ended      = out_res_reg.visit_ended;
    assign events.visit_begin_time = out_res_reg.visit_begin_time;
    assign events.visit_duration   = out_res_reg.visit_duration;
    assign events.visit_peak       = out_res_reg.visit_peak;

    `VEDU_ASSERT_IMPL(a_ready_low_only_when_full, !samples.ready, s1_valid_reg && out_valid_reg, "input stalled while a register was free")
    `VEDU_ASSERT_NEXT(a_advance_fills_result, advance, out_valid_reg, "item advanced but no result was held")
    `VEDU_ASSERT_IMPL(a_no_start_no_rise, out_valid_reg && !out_res_reg.visit_started, out_res_reg.start_rise == '0, "start rise set without a visit start")
    `VEDU_ASSERT_IMPL(a_no_end_no_fields, out_valid_reg && !out_res_reg.visit_ended, (out_res_reg.visit_duration == '0) && (out_res_reg.visit_peak == '0), "visit end fields set without a visit end")

endmodule

`default_nettype wire
